FILE: rtl/u8cp_pkg.sv
// shared types, constants and the single-lead scan function for the utf-8 decoder
// no dependencies; used by u8cp_ctrl, u8cp_datapath and the top level
package u8cp_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UTF8_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_TERM = 2'd1;

    // field widths
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // byte classes and masks
    localparam logic [7:0]      LEAD_2B     = 8'h80;
    localparam logic [7:0]      LEAD_3B     = 8'hE0;
    localparam logic [7:0]      LEAD_4B     = 8'hF0;
    localparam logic [7:0]      MASK_2B     = 8'h1F;
    localparam logic [7:0]      MASK_3B     = 8'h0F;
    localparam logic [7:0]      MASK_4B     = 8'h07;
    localparam logic [1:0]      CONT_TAG    = 2'b10;
    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // outcome of scanning one lead
    typedef enum logic [2:0] {
        K_END   = 3'd0,   // nothing left to scan
        K_LATIN = 3'd1,   // byte passed through
        K_ZERO  = 3'd2,   // terminating zero
        K_GOOD  = 3'd3,   // complete sequence
        K_BAD   = 3'd4,   // malformed lead, replacement emitted
        K_HOLD  = 3'd5    // sequence open, bytes kept for the next transfer
    } step_kind_t;

    typedef struct packed {
        step_kind_t      kind;
        logic [CP_W-1:0] cp;
        logic            rep;
        logic            txt;
        logic [2:0]      adv;
    } step_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic keep;
    } u8cp_cmd_t;

    // datapath to controller
    typedef struct packed {
        step_kind_t kind;
        logic       last;
        logic       out_free;
    } u8cp_status_t;

    // evaluate the lead at pos against the bytes that follow it in the window
    function automatic step_t scan_step(
        input logic [3:0][7:0] win,
        input logic [2:0]      len,
        input logic [2:0]      pos,
        input logic            utf8,
        input logic            zt,
        input logic            ce
    );
        step_t           r;
        logic [7:0]      lead;
        logic [7:0]      nb;
        logic [1:0]      extra;
        logic [CP_W-1:0] cp;
        logic            stop;
        logic            cut;
        logic            bad;
        logic [2:0]      idx;
        r     = '0;
        r.kind = K_END;
        lead  = win[pos[1:0]];
        nb    = '0;
        extra = '0;
        cp    = '0;
        stop  = 1'b0;
        cut   = 1'b0;
        bad   = 1'b0;
        idx   = '0;
        if (pos < len) begin
            if (!utf8) begin
                r.kind = K_LATIN;
                r.cp   = {13'd0, lead};
                r.txt  = ce | (zt & (lead == 8'd0));
                r.adv  = 3'd1;
            end else if (zt && (lead == 8'd0)) begin
                r.kind = K_ZERO;
                r.txt  = 1'b1;
                r.adv  = 3'd1;
            end else begin
                // lead class
                if (lead < LEAD_2B) begin
                    cp = {13'd0, lead};           extra = 2'd0;
                end else if (lead < LEAD_3B) begin
                    cp = {13'd0, lead & MASK_2B}; extra = 2'd1;
                end else if (lead < LEAD_4B) begin
                    cp = {13'd0, lead & MASK_3B}; extra = 2'd2;
                end else begin
                    cp = {13'd0, lead & MASK_4B}; extra = 2'd3;
                end
                // continuation bytes, six bits each
                for (int k = 1; k <= 3; k++) begin
                    idx = pos + 3'(k);
                    if (!stop && (2'(k) <= extra)) begin
                        if (idx >= len) begin
                            cut  = 1'b1;
                            stop = 1'b1;
                        end else begin
                            nb = win[idx[1:0]];
                            if (nb[7:6] != CONT_TAG) begin
                                bad  = 1'b1;
                                stop = 1'b1;
                            end else begin
                                cp = {cp[CP_W-7:0], nb[5:0]};
                            end
                        end
                    end
                end
                if (cut && !ce) begin
                    r.kind = K_HOLD;
                    r.adv  = len - pos;
                end else if (cut || bad) begin
                    r.kind = K_BAD;
                    r.cp   = REPLACEMENT;
                    r.rep  = 1'b1;
                    r.adv  = 3'd1;
                end else begin
                    r.kind = K_GOOD;
                    r.cp   = cp;
                    r.adv  = {1'b0, extra} + 3'd1;
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/utf8_to_codepoint_decoder_top.sv
// UTF-8 to code point decoder. Each input transfer carries one text byte; each output
// transfer carries one code point. A byte is taken, then the sequencer evaluates one
// lead per cycle, unless the output is stalled, from a window of up to three held
// bytes plus the new byte, until the byte's results are given or it only extends an
// open sequence.
// The result register lets the last result of a byte wait while the next byte is taken.
// Configuration writes are accepted in every cycle; a write to a defined index restarts the text.
//
// top level: stream ports and packing; depends on u8cp_pkg, u8cp_ctrl, u8cp_datapath
module utf8_to_codepoint_decoder_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [u8cp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data,
    // input bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // end_of_text
    // code points
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]                       m_tuser,   // [0] replaced, [1] run_last
    output logic                             m_tlast    // text_last
);
    import u8cp_pkg::*;

    u8cp_cmd_t       cmd;
    u8cp_status_t    status;
    logic [CP_W-1:0] cp;
    logic            rep;
    logic            run_last;
    logic            text_last;

    // sequencer
    u8cp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // window, config and result register
    u8cp_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_byte       (s_tdata),
        .in_end        (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_cp        (cp),
        .out_rep       (rep),
        .out_run_last  (run_last),
        .out_text_last (text_last),
        .cmd           (cmd),
        .status        (status)
    );

    // output packing
    assign m_tdata = {3'd0, cp};
    assign m_tuser = {run_last, rep};
    assign m_tlast = text_last;

endmodule

FILE: rtl/u8cp_ctrl.sv
// sequencer for the utf-8 decoder: takes a byte, then walks the leads one per cycle while the output is free
// depends on u8cp_pkg for the command and status structs
module u8cp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  u8cp_pkg::u8cp_status_t status,
    output u8cp_pkg::u8cp_cmd_t    cmd
);
    import u8cp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        emits;

    // results that go to the output register
    assign emits = (status.kind == K_LATIN) || (status.kind == K_ZERO) ||
                   (status.kind == K_GOOD)  || (status.kind == K_BAD);

    // commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.kind == K_HOLD) begin
                    cmd.keep   = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.kind == K_END) begin
                    state_next = ST_IDLE;
                end else if (emits && status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/u8cp_datapath.sv
// datapath of the utf-8 decoder: byte window, held count, config and output register
// depends on u8cp_pkg for scan_step and the command and status structs
module u8cp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [u8cp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic                                cfg_data,
    // input byte
    input  logic [u8cp_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                in_end,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [u8cp_pkg::CP_W-1:0]           out_cp,
    output logic                                out_rep,
    output logic                                out_run_last,
    output logic                                out_text_last,
    // control
    input  u8cp_pkg::u8cp_cmd_t                 cmd,
    output u8cp_pkg::u8cp_status_t              status
);
    import u8cp_pkg::*;

    // configuration
    logic utf8_mode_reg;
    logic zero_term_reg;

    // byte window: held bytes then the new byte
    logic [3:0][7:0] win_reg;
    logic [2:0]      len_reg;
    logic [1:0]      pos_reg;
    logic [1:0]      held_count_reg;
    logic            ce_reg;
    logic [1:0]      base;

    // output register
    logic            m_tvalid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            rep_reg;
    logic            run_last_reg;
    logic            text_last_reg;

    step_t      cur;
    step_t      nxt;
    logic [2:0] next_pos;
    logic       last;
    logic       hold_after;
    logic [1:0] shift_pos;

    assign cfg_ready = 1'b1;

    // scan the current lead and look one lead ahead to see if this result ends the run
    always_comb begin
        cur      = scan_step(win_reg, len_reg, {1'b0, pos_reg}, utf8_mode_reg,
                             zero_term_reg, ce_reg);
        next_pos = {1'b0, pos_reg} + cur.adv;
        nxt      = scan_step(win_reg, len_reg, next_pos, utf8_mode_reg,
                             zero_term_reg, ce_reg);
        last     = (cur.kind == K_LATIN) || (cur.kind == K_ZERO) ||
                   (nxt.kind == K_END)   || (nxt.kind == K_HOLD);
    end

    assign status.kind     = cur.kind;
    assign status.last     = last;
    assign status.out_free = !m_tvalid_reg || m_tready;

    // open sequence left behind the last result of a byte is kept with that result
    assign hold_after = cmd.emit && (nxt.kind == K_HOLD);
    assign shift_pos  = cmd.keep ? pos_reg : next_pos[1:0];

    // held bytes only count in utf-8 mode
    assign base = utf8_mode_reg ? held_count_reg : 2'd0;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_mode_reg  <= 1'b1;
            zero_term_reg  <= 1'b0;
            held_count_reg <= 2'd0;
            pos_reg        <= 2'd0;
            len_reg        <= 3'd0;
            ce_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // configuration write to a defined index restarts the text
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_UTF8_MODE: begin
                        utf8_mode_reg  <= cfg_data;
                        held_count_reg <= 2'd0;
                    end
                    CFG_ZERO_TERM: begin
                        zero_term_reg  <= cfg_data;
                        held_count_reg <= 2'd0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.load) begin
                len_reg        <= {1'b0, base} + 3'd1;
                pos_reg        <= 2'd0;
                ce_reg         <= !zero_term_reg && in_end;
                held_count_reg <= 2'd0;
            end
            if (cmd.keep) begin
                held_count_reg <= cur.adv[1:0];
            end else if (hold_after) begin
                held_count_reg <= nxt.adv[1:0];
            end
            if (cmd.emit && !last) begin
                pos_reg <= next_pos[1:0];
            end
            // output valid
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // window and output payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            win_reg[base] <= in_byte;
        end
        if (cmd.keep || hold_after) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i] <= win_reg[shift_pos + 2'(i)];
            end
        end
        if (cmd.emit) begin
            cp_reg        <= cur.cp;
            rep_reg       <= cur.rep;
            run_last_reg  <= last;
            text_last_reg <= cur.txt | (ce_reg & last);
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign out_cp        = cp_reg;
    assign out_rep       = rep_reg;
    assign out_run_last  = run_last_reg;
    assign out_text_last = text_last_reg;

endmodule
